/* rtl/baud_sweep_top_score_table_unit_defines.svh */
// assertion macros for the baud sweep score table
`ifndef BAUD_SWEEP_TOP_SCORE_TABLE_UNIT_DEFINES_SVH
`define BAUD_SWEEP_TOP_SCORE_TABLE_UNIT_DEFINES_SVH

// property checked on every rising edge outside reset
`define BSTS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("bsts assertion failed");

// implication form
`define BSTS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	`BSTS_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

/* rtl/bsts_pkg.sv */
// types and constants of the baud sweep score table
`timescale 1ns / 1ps

package bsts_pkg;

	typedef logic [1:0] req_t;

	localparam req_t REQ_TICK  = 2'd0;
	localparam req_t REQ_START = 2'd1;
	localparam req_t REQ_STOP  = 2'd2;
	localparam req_t REQ_READ  = 2'd3;

	typedef logic [1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_START    = 2'd0;
	localparam cfg_idx_t CFG_END      = 2'd1;
	localparam cfg_idx_t CFG_STEP     = 2'd2;
	localparam cfg_idx_t CFG_INTERVAL = 2'd3;

	localparam logic [19:0] BAUD_MIN     = 20'd300;
	localparam logic [19:0] BAUD_MAX     = 20'd921600;
	localparam logic [15:0] INTERVAL_MIN = 16'd50;
	localparam logic [6:0]  SCORE_EXACT  = 7'd96;
	localparam logic [6:0]  SCORE_BASE   = 7'd80;
	localparam int          NUM_RATES    = 5;

	localparam logic [19:0] STD_RATES [NUM_RATES] = '{
		20'd9600, 20'd19200, 20'd38400, 20'd57600, 20'd115200
	};

	// result payload, first field in the highest bits
	typedef struct packed {
		logic        pad;
		logic [7:0]  entry_bytes;
		logic [6:0]  entry_score;
		logic [19:0] entry_baud;
		logic [4:0]  entry_count;
		logic [20:0] cursor_baud;
		logic        running;
		logic        start_accepted;
	} res_t;

endpackage

/* rtl/baud_sweep_top_score_table_unit.sv */
// baud sweep with a top-score result table held in one synchronous memory
// a start, stop, idle or waiting tick goes straight to the output register; a read waits on one memory read;
// a sampling tick runs the search and the divide, and scans the table when it is full
// (5-step nearest-rate search, 20-step serial divide, one memory read per entry)
// one item at a time; the next item is taken once the result is in the output register
// arst_n clears control state, config registers take their defaults; table contents undefined
`timescale 1ns / 1ps

module baud_sweep_top_score_table_unit #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // read_index, zero pad
	input  logic [1:0]  s_axis_tuser,   // req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata    // start_accepted, running, cursor_baud, entry_count,
	                                    // entry_baud, entry_score, entry_bytes, zero pad
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = 27;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEAR = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_REC  = 3'd3;
	localparam logic [2:0] ST_SCAN = 3'd4;
	localparam logic [2:0] ST_REPL = 3'd5;
	localparam logic [2:0] ST_RDW  = 3'd6;
	localparam logic [2:0] ST_PUSH = 3'd7;

	logic [2:0]  state_q;

	logic [19:0] cfg_start_q, cfg_end_q, cfg_step_q;
	logic [15:0] cfg_intv_q;

	logic        active_q, sampled_q;
	logic [20:0] cand_q;
	logic [15:0] ticks_q, intv_q;
	logic [CW-1:0] cnt_q;
	logic [19:0] end_q, step_q;

	logic [19:0] baud_q, best_q, quo_q, rem_q;
	logic [2:0]  k_q;
	logic [4:0]  div_cnt_q;
	logic [6:0]  score_q;
	logic [CW-1:0] scan_q;
	logic        rd_v_s1;
	logic [AW-1:0] rd_idx_s1;
	logic [AW-1:0] worst_idx_q;
	logic [6:0]  worst_sc_q;
	logic        accepted_q, rd_ok_q;
	logic [19:0] ebaud_q;
	logic [6:0]  esc_q;

	bsts_pkg::res_t out_q;
	logic        out_valid_q;

	logic [MW-1:0] mem [TABLE_DEPTH];
	logic [MW-1:0] mem_rd_q;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [MW-1:0] mem_wd;

	logic        in_xfer;
	bsts_pkg::req_t req;
	logic [3:0]  rd_index;
	logic [15:0] ticks_inc;
	logic        take;
	logic        start_ok;
	logic [19:0] near_d, best_next;
	logic [20:0] div_sh, div_trial;
	logic [6:0]  sc;
	logic        full;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign req           = s_axis_tuser;
	assign rd_index      = s_axis_tdata[3:0];
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;

	assign ticks_inc = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign take      = !sampled_q || (ticks_inc >= intv_q);
	assign start_ok  = !(cfg_start_q < bsts_pkg::BAUD_MIN || cfg_end_q > bsts_pkg::BAUD_MAX ||
		cfg_end_q <= cfg_start_q || cfg_step_q == 20'd0);
	assign full      = (cnt_q == CW'(TABLE_DEPTH));

	always_comb begin
		logic [19:0] rate;
		rate      = bsts_pkg::STD_RATES[k_q];
		near_d    = (rate > baud_q) ? rate - baud_q : baud_q - rate;
		best_next = (k_q == 3'd0 || near_d < best_q) ? near_d : best_q;
	end

	assign div_sh    = {rem_q, quo_q[19]};
	assign div_trial = div_sh - {1'b0, step_q};

	always_comb begin
		if (best_q == 20'd0) begin
			sc = bsts_pkg::SCORE_EXACT;
		end else if (quo_q >= 20'(bsts_pkg::SCORE_BASE)) begin
			sc = 7'd0;
		end else begin
			sc = bsts_pkg::SCORE_BASE - quo_q[6:0];
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = cnt_q[AW-1:0];
		mem_wd = {score_q, baud_q};
		mem_re = 1'b0;
		mem_ra = AW'(rd_index);
		case (state_q)
			ST_IDLE: begin
				mem_re = in_xfer && (req == bsts_pkg::REQ_READ);
			end
			ST_REC: begin
				mem_we = !full;
				mem_wd = {sc, baud_q};
			end
			ST_SCAN: begin
				mem_re = (scan_q != CW'(TABLE_DEPTH));
				mem_ra = scan_q[AW-1:0];
			end
			ST_REPL: begin
				mem_we = (score_q > worst_sc_q);
				mem_wa = worst_idx_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			mem_rd_q <= mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_start_q <= 20'd9600;
			cfg_end_q   <= 20'd115200;
			cfg_step_q  <= 20'd9600;
			cfg_intv_q  <= 16'd50;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsts_pkg::CFG_START:    cfg_start_q <= cfg_data;
				bsts_pkg::CFG_END:      cfg_end_q   <= cfg_data;
				bsts_pkg::CFG_STEP:     cfg_step_q  <= cfg_data;
				bsts_pkg::CFG_INTERVAL: cfg_intv_q  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// payload registers of the work sequence
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					accepted_q <= (req == bsts_pkg::REQ_START) && start_ok;
					rd_ok_q    <= (32'(rd_index) < 32'(cnt_q));
					ebaud_q    <= 20'd0;
					esc_q      <= 7'd0;
					baud_q     <= cand_q[19:0];
				end
			end
			ST_NEAR: begin
				best_q <= best_next;
				quo_q  <= best_next;
				rem_q  <= 20'd0;
			end
			ST_DIV: begin
				if (!div_trial[20]) begin
					rem_q <= div_trial[19:0];
					quo_q <= {quo_q[18:0], 1'b1};
				end else begin
					rem_q <= div_sh[19:0];
					quo_q <= {quo_q[18:0], 1'b0};
				end
			end
			ST_REC: begin
				score_q <= sc;
			end
			ST_SCAN: begin
				if (rd_v_s1 && (rd_idx_s1 == '0 || mem_rd_q[26:20] < worst_sc_q)) begin
					worst_idx_q <= rd_idx_s1;
					worst_sc_q  <= mem_rd_q[26:20];
				end
			end
			ST_RDW: begin
				if (rd_ok_q) begin
					ebaud_q <= mem_rd_q[19:0];
					esc_q   <= mem_rd_q[26:20];
				end
			end
			default: begin
			end
		endcase
		if (state_q == ST_PUSH && (!out_valid_q || m_axis_tready)) begin
			out_q.pad            <= 1'b0;
			out_q.start_accepted <= accepted_q;
			out_q.running        <= active_q;
			out_q.cursor_baud    <= cand_q;
			out_q.entry_count    <= 5'(cnt_q);
			out_q.entry_baud     <= ebaud_q;
			out_q.entry_score    <= esc_q;
			out_q.entry_bytes    <= {esc_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= 1'b0;
			sampled_q   <= 1'b0;
			cand_q      <= 21'd0;
			ticks_q     <= 16'd0;
			intv_q      <= bsts_pkg::INTERVAL_MIN;
			cnt_q       <= '0;
			end_q       <= 20'd0;
			step_q      <= 20'd0;
			k_q         <= 3'd0;
			div_cnt_q   <= 5'd0;
			scan_q      <= '0;
			rd_v_s1     <= 1'b0;
			rd_idx_s1   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_v_s1   <= (state_q == ST_SCAN) && mem_re;
			rd_idx_s1 <= mem_ra;
			if (state_q == ST_PUSH && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						case (req)
							bsts_pkg::REQ_TICK: begin
								if (active_q && take && (cand_q <= {1'b0, end_q})) begin
									state_q <= ST_NEAR;
								end else begin
									state_q <= ST_PUSH;
								end
								if (active_q) begin
									if (take) begin
										sampled_q <= 1'b1;
										ticks_q   <= 16'd0;
										if (cand_q > {1'b0, end_q}) begin
											active_q <= 1'b0;
										end else begin
											cand_q <= cand_q + {1'b0, step_q};
											k_q    <= 3'd0;
										end
									end else begin
										ticks_q <= ticks_inc;
									end
								end
							end
							bsts_pkg::REQ_START: begin
								state_q <= ST_PUSH;
								if (start_ok) begin
									active_q  <= 1'b1;
									end_q     <= cfg_end_q;
									step_q    <= cfg_step_q;
									intv_q    <= (cfg_intv_q < bsts_pkg::INTERVAL_MIN) ?
										bsts_pkg::INTERVAL_MIN : cfg_intv_q;
									cand_q    <= {1'b0, cfg_start_q};
									sampled_q <= 1'b0;
									ticks_q   <= 16'd0;
									cnt_q     <= '0;
								end
							end
							bsts_pkg::REQ_STOP: begin
								state_q  <= ST_PUSH;
								active_q <= 1'b0;
							end
							bsts_pkg::REQ_READ: begin
								state_q <= ST_RDW;
							end
							default: begin
								state_q <= ST_PUSH;
							end
						endcase
					end
				end
				ST_NEAR: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'(bsts_pkg::NUM_RATES - 1)) begin
						div_cnt_q <= 5'd0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd19) begin
						state_q <= ST_REC;
					end
				end
				ST_REC: begin
					if (!full) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= ST_PUSH;
					end else begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (mem_re) begin
						scan_q <= scan_q + CW'(1);
					end else if (!rd_v_s1) begin
						state_q <= ST_REPL;
					end
				end
				ST_REPL: begin
					state_q <= ST_PUSH;
				end
				ST_RDW: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/bsts_checker.sv */
// port checks for the baud sweep score table, bound to the top level
`timescale 1ns / 1ps
`include "baud_sweep_top_score_table_unit_defines.svh"

module bsts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	bsts_pkg::res_t res;

	assign res = m_axis_tdata;

	`BSTS_ASSERT_IMPL(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, ##1 (m_axis_tvalid && $stable(m_axis_tdata)))
	`BSTS_ASSERT_IMPL(a_bytes_twice, clk, arst_n, m_axis_tvalid, (res.entry_bytes[0] == 1'b0) && (res.entry_bytes[7:1] == res.entry_score))
	`BSTS_ASSERT_IMPL(a_score_range, clk, arst_n, m_axis_tvalid, res.entry_score <= bsts_pkg::SCORE_EXACT)
	`BSTS_ASSERT_IMPL(a_start_runs, clk, arst_n, m_axis_tvalid && res.start_accepted, res.running && (res.entry_count == 5'd0))

endmodule

bind baud_sweep_top_score_table_unit bsts_checker u_bsts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
